[rtl/dbr_pkg.sv]
// ----------------------------------------------------------------------------
// dbr_pkg
// Shared types and constants for the button debounce and report scheduler.
// ----------------------------------------------------------------------------
package dbr_pkg;

	// Fixed field widths.
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned PIN_W = 8;
	localparam int unsigned IDX_W = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_RESEND = 2'd1;
	localparam logic [IDX_W-1:0] REG_BLINK = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] RESEND_RST = 16'd100;
	localparam logic [CFG_W-1:0] BLINK_RST = 16'd500;

	// Configuration register set.
	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] resend_ms;
		logic [CFG_W-1:0] blink_ms;
	} dbr_cfg_t;

	// Per-button result of one sample.
	typedef struct packed {
		logic debounced;
		logic changed;
	} dbr_chan_t;

	// Scheduler result of one sample.
	typedef struct packed {
		logic send;
		logic led;
	} dbr_sched_t;

endpackage

[rtl/dbr_channel.sv]
// ----------------------------------------------------------------------------
// dbr_channel
// Debouncer for one button: previous raw reading, change stamp and debounced
// state, updated once per accepted sample.
// ----------------------------------------------------------------------------
module dbr_channel (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [dbr_pkg::TIME_W-1:0]   now_ms,
	input  logic                         reading,
	input  logic [dbr_pkg::CFG_W-1:0]    debounce_ms,
	output dbr_pkg::dbr_chan_t           status
);
	import dbr_pkg::*;

	logic              prev_q;
	logic              state_q;
	logic [TIME_W-1:0] stamp_q;
	logic [TIME_W-1:0] elapsed;
	logic              stable;

	// A fresh edge is never stable, as the stamp restarts on it; otherwise compare
	// the time elapsed since the stored stamp against the delay.
	always_comb begin
		elapsed = now_ms - stamp_q;
		stable = (reading == prev_q) && (elapsed > {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
		status.changed = stable && (reading != state_q);
		status.debounced = stable ? reading : state_q;
	end

	// State update on each processed sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			state_q <= 1'b0;
			stamp_q <= '0;
		end else if (en) begin
			prev_q <= reading;
			state_q <= status.debounced;
			if (reading != prev_q) begin
				stamp_q <= now_ms;
			end
		end
	end

endmodule

[rtl/dbr_sched.sv]
// ----------------------------------------------------------------------------
// dbr_sched
// Report scheduling and power LED blinking, both driven by elapsed time
// since their last event.
// ----------------------------------------------------------------------------
module dbr_sched (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [dbr_pkg::TIME_W-1:0]   now_ms,
	input  logic                         changed_any,
	input  logic                         held_any,
	input  dbr_pkg::dbr_cfg_t            cfg,
	output dbr_pkg::dbr_sched_t          result
);
	import dbr_pkg::*;

	logic [TIME_W-1:0] report_stamp_q;
	logic [TIME_W-1:0] toggle_stamp_q;
	logic              led_q;
	logic              toggle;
	logic              periodic;

	// Blink toggle and periodic resend decisions.
	always_comb begin
		toggle = (now_ms - toggle_stamp_q) >= {{(TIME_W-CFG_W){1'b0}}, cfg.blink_ms};
		periodic = held_any &&
			((now_ms - report_stamp_q) >= {{(TIME_W-CFG_W){1'b0}}, cfg.resend_ms});
		result.send = changed_any || periodic;
		result.led = led_q ^ toggle;
	end

	// Timing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_stamp_q <= '0;
			toggle_stamp_q <= '0;
			led_q <= 1'b0;
		end else if (en) begin
			led_q <= result.led;
			if (toggle) begin
				toggle_stamp_q <= now_ms;
			end
			if (result.send) begin
				report_stamp_q <= now_ms;
			end
		end
	end

endmodule

[rtl/button_debounce_report_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// button_debounce_report_scheduler_unit
// Eight-channel timestamp debouncer with report scheduling and status LEDs.
// ----------------------------------------------------------------------------
// Each item is one sample (millisecond timestamp and active-low pin levels)
// and yields exactly one result item: report flag, debounced pressed mask,
// power LED level and busy LED. A sample is registered on acceptance, then
// evaluated from the input register by the per-button comparators and the
// report scheduler, whose outputs land in the result register once it is
// free. One item is taken every cycle while the result channel does not
// stall. The result register and the input register form two stages, so
// one more sample is still taken while a result waits under stall; once
// both stages are full, the input stall follows the output stall in the
// same cycle. Buttons at or above BUTTON_COUNT are ignored and read as
// released. Configuration writes are always ready; unknown indexes are
// ignored.
// ----------------------------------------------------------------------------
module button_debounce_report_scheduler_unit #(
	parameter int unsigned BUTTON_COUNT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Sample channel.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dbr_pkg::TIME_W-1:0]   now_ms,
	input  logic [dbr_pkg::PIN_W-1:0]    pin_levels,
	// Result channel.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         report_valid,
	output logic [dbr_pkg::PIN_W-1:0]    report_mask,
	output logic                         power_led,
	output logic                         busy_led,
	// Configuration write channel.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dbr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dbr_pkg::CFG_W-1:0]    cfg_data
);
	import dbr_pkg::*;

	dbr_cfg_t          cfg_q;
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic [PIN_W-1:0]  pins_s1;
	logic              advance;
	logic [PIN_W-1:0]  mask_next;
	logic [PIN_W-1:0]  chg_vec;
	dbr_sched_t        sched;
	logic              out_valid_q;
	logic              report_q;
	logic [PIN_W-1:0]  mask_q;
	logic              power_q;
	logic              busy_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.resend_ms <= RESEND_RST;
			cfg_q.blink_ms <= BLINK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data;
				REG_RESEND: cfg_q.resend_ms <= cfg_data;
				REG_BLINK: cfg_q.blink_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the evaluate stage advances when the result register is free.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1 <= now_ms;
			pins_s1 <= pin_levels;
		end
	end

	// Per-button debouncers.
	for (genvar i = 0; i < PIN_W; i++) begin : g_btn
		if (i < BUTTON_COUNT) begin : g_used
			dbr_chan_t st;
			dbr_channel u_chan (
				.clk         (clk),
				.arst_n      (arst_n),
				.en          (advance),
				.now_ms      (now_s1),
				.reading     (~pins_s1[i]),
				.debounce_ms (cfg_q.debounce_ms),
				.status      (st)
			);
			assign mask_next[i] = st.debounced;
			assign chg_vec[i] = st.changed;
		end else begin : g_unused
			assign mask_next[i] = 1'b0;
			assign chg_vec[i] = 1'b0;
		end
	end

	// Report and LED scheduling.
	dbr_sched u_sched (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.now_ms      (now_s1),
		.changed_any (|chg_vec),
		.held_any    (|mask_next),
		.cfg         (cfg_q),
		.result      (sched)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			report_q <= sched.send;
			mask_q <= mask_next;
			power_q <= sched.led;
			busy_q <= |mask_next;
		end
	end

	assign out_valid = out_valid_q;
	assign report_valid = report_q;
	assign report_mask = mask_q;
	assign power_led = power_q;
	assign busy_led = busy_q;

endmodule

[tb/debounce_report_checker.sv]
// ----------------------------------------------------------------------------
// debounce_report_checker
// Watches the sample, result and configuration channels of the debounce and
// report scheduler. It keeps its own copy of the debouncer state, predicts
// one result for every accepted sample and compares each accepted result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module debounce_report_checker #(
	parameter int unsigned BUTTON_COUNT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [dbr_pkg::TIME_W-1:0]   now_ms,
	input  logic [dbr_pkg::PIN_W-1:0]    pin_levels,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         report_valid,
	input  logic [dbr_pkg::PIN_W-1:0]    report_mask,
	input  logic                         power_led,
	input  logic                         busy_led,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [dbr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dbr_pkg::CFG_W-1:0]    cfg_data,
	output int                           outstanding,
	output int                           fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import dbr_pkg::*;

	localparam logic [PIN_W-1:0] USED_MASK = PIN_W'((1 << BUTTON_COUNT) - 1);
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		logic             report_valid;
		logic [PIN_W-1:0] report_mask;
		logic             power_led;
		logic             busy_led;
	} report_t;

	// Shadow configuration and debouncer state.
	dbr_cfg_t          cfg_copy;
	logic [PIN_W-1:0]  prev_pressed;
	logic [TIME_W-1:0] change_stamp [PIN_W];
	logic [PIN_W-1:0]  stable_pressed;
	logic [TIME_W-1:0] last_report;
	logic [TIME_W-1:0] last_toggle;
	logic              led_level;

	report_t pending_reports [$];

	initial fail_count = 0;
	initial outstanding = 0;

	// Advance the shadow state by one sample and return the result it causes.
	function automatic report_t debounce_sample(input logic [TIME_W-1:0] stamp,
			input logic [PIN_W-1:0] pins);
		logic [PIN_W-1:0]  pressed;
		logic [TIME_W-1:0] elapsed;
		logic              changed;
		logic              periodic;
		report_t           res;
		pressed = ~pins & USED_MASK;
		changed = 1'b0;
		elapsed = stamp - last_toggle;
		if (elapsed >= TIME_W'(cfg_copy.blink_ms)) begin
			last_toggle = stamp;
			led_level = ~led_level;
		end
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			if (pressed[i] != prev_pressed[i]) begin
				change_stamp[i] = stamp;
			end
			elapsed = stamp - change_stamp[i];
			if (elapsed > TIME_W'(cfg_copy.debounce_ms) &&
					pressed[i] != stable_pressed[i]) begin
				stable_pressed[i] = pressed[i];
				changed = 1'b1;
			end
		end
		prev_pressed = pressed;
		stable_pressed = stable_pressed & USED_MASK;
		elapsed = stamp - last_report;
		periodic = (stable_pressed != '0) && (elapsed >= TIME_W'(cfg_copy.resend_ms));
		if (changed || periodic) begin
			last_report = stamp;
		end
		res.report_valid = changed || periodic;
		res.report_mask = stable_pressed;
		res.power_led = led_level;
		res.busy_led = (stable_pressed != '0);
		return res;
	endfunction

	// Track configuration writes, predict on sample items, check result items.
	always @(posedge clk or negedge arst_n) begin : monitor
		report_t want;
		report_t got;
		if (!arst_n) begin
			cfg_copy.debounce_ms = DEBOUNCE_RST;
			cfg_copy.resend_ms = RESEND_RST;
			cfg_copy.blink_ms = BLINK_RST;
			prev_pressed = '0;
			for (int i = 0; i < PIN_W; i++) begin
				change_stamp[i] = '0;
			end
			stable_pressed = '0;
			last_report = '0;
			last_toggle = '0;
			led_level = 1'b0;
			pending_reports.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE: cfg_copy.debounce_ms = cfg_data;
					REG_RESEND:   cfg_copy.resend_ms = cfg_data;
					REG_BLINK:    cfg_copy.blink_ms = cfg_data;
					default:      ;
				endcase
			end
			if (in_valid && !in_stall) begin
				pending_reports.push_back(debounce_sample(now_ms, pin_levels));
			end
			if (out_valid && !out_stall) begin
				got.report_valid = report_valid;
				got.report_mask = report_mask;
				got.power_led = power_led;
				got.busy_led = busy_led;
				if (pending_reports.size() == 0) begin
					if (fail_count < MAX_REPORTED) begin
						$display("%t: result item with nothing expected: valid=%0b mask=%h led=%0b busy=%0b",
							$realtime, got.report_valid, got.report_mask, got.power_led,
							got.busy_led);
					end
					fail_count++;
				end else begin
					want = pending_reports.pop_front();
					if (got.report_valid !== want.report_valid ||
							got.report_mask !== want.report_mask ||
							got.power_led !== want.power_led ||
							got.busy_led !== want.busy_led) begin
						if (fail_count < MAX_REPORTED) begin
							$display("%t: mismatch: expected valid=%0b mask=%h led=%0b busy=%0b, got valid=%0b mask=%h led=%0b busy=%0b",
								$realtime, want.report_valid, want.report_mask,
								want.power_led, want.busy_led, got.report_valid,
								got.report_mask, got.power_led, got.busy_led);
						end
						fail_count++;
					end
				end
			end
		end
		outstanding <= pending_reports.size();
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the button debounce and report scheduler. A short
// directed sequence covers press and release, the debounce window edge,
// repeated reports, LED blinking, glitches, timestamp wrap and zero
// intervals; random sequences of held button patterns with varied time steps
// follow under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dbr_pkg::*;

	localparam int ITEMS_PER_SEGMENT = 175;
	localparam int SEGMENTS = 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	// Register index that selects no register.
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [TIME_W-1:0]   now_ms = '0;
	logic [PIN_W-1:0]    pin_levels = '1;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                report_valid;
	logic [PIN_W-1:0]    report_mask;
	logic                power_led;
	logic                busy_led;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;

	int outstanding;
	int fail_count;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	button_debounce_report_scheduler_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.now_ms(now_ms), .pin_levels(pin_levels),
		.out_valid(out_valid), .out_stall(out_stall),
		.report_valid(report_valid), .report_mask(report_mask),
		.power_led(power_led), .busy_led(busy_led),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	debounce_report_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.now_ms(now_ms), .pin_levels(pin_levels),
		.out_valid(out_valid), .out_stall(out_stall),
		.report_valid(report_valid), .report_mask(report_mask),
		.power_led(power_led), .busy_led(busy_led),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("button_debounce_report_scheduler_unit verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one sample item, idling at random first, and wait until it is taken.
	task automatic send_sample(input logic [TIME_W-1:0] stamp, input logic [PIN_W-1:0] pins);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= stamp;
		pin_levels <= pins;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	// Write one register; valid stays high for a following write.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_all(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] resend,
			input logic [CFG_W-1:0] blink);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_RESEND, resend);
		write_reg(REG_BLINK, blink);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [TIME_W-1:0] stamp;
		logic [PIN_W-1:0]  held_pins;
		logic [PIN_W-1:0]  pins;
		int                pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: press, window edge, acceptance, repeated report.
		send_sample(32'd0, 8'hFF);
		send_sample(32'd10, 8'hFE);
		send_sample(32'd60, 8'hFE);
		send_sample(32'd61, 8'hFE);
		send_sample(32'd100, 8'hFE);
		send_sample(32'd161, 8'hFE);
		// All buttons pressed together, then released together.
		send_sample(32'd170, 8'h00);
		send_sample(32'd221, 8'h00);
		send_sample(32'd230, 8'hFF);
		send_sample(32'd281, 8'hFF);
		// Power LED blink boundaries.
		send_sample(32'd500, 8'hFF);
		send_sample(32'd999, 8'hFF);
		send_sample(32'd1000, 8'hFF);
		// A glitch shorter than the window never reaches the debounced state.
		send_sample(32'd1100, 8'hFD);
		send_sample(32'd1120, 8'hFF);
		send_sample(32'd1200, 8'hFF);
		// Timestamp wrap, then a timestamp that goes back.
		send_sample(32'hFFFF_FFF0, 8'h7F);
		send_sample(32'h0000_0030, 8'h7F);
		send_sample(32'h0000_0020, 8'h7F);
		send_sample(32'hFFFF_FFFF, 8'hAA);
		send_sample(32'h0000_0000, 8'h55);

		// Zero debounce and zero intervals.
		settle();
		write_all(16'd0, 16'd0, 16'd0);
		send_sample(32'd200, 8'h00);
		send_sample(32'd201, 8'h00);
		send_sample(32'd201, 8'h00);
		send_sample(32'd202, 8'hFF);

		// Random sequences of held patterns with glitches and varied time steps.
		stamp = $urandom();
		held_pins = 8'hFF;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			case (seg)
				0: write_all(16'd20, 16'd50, 16'd100);
				1: write_all(16'd0, 16'd1, 16'd1);
				2: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: begin
					write_reg(REG_UNUSED, CFG_W'($urandom()));
					write_all(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(1, 300)),
						CFG_W'($urandom_range(1, 1000)));
				end
				4: write_all(CFG_W'($urandom_range(0, 60)), 16'd0, 16'd0);
				default: write_all(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
			endcase
			case (seg / 2)
				0: begin
					send_idle_pct = 27;
					recv_stall_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_stall_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					stamp = stamp + $urandom_range(0, 40);
				end else if (pick < 90) begin
					stamp = stamp + $urandom_range(0, 400);
				end else if (pick < 97) begin
					stamp = stamp + $urandom_range(0, 70000);
				end else begin
					stamp = $urandom();
				end
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					held_pins = PIN_W'($urandom_range(0, 255));
				end else if (pick < 16) begin
					held_pins = held_pins ^ PIN_W'(1 << $urandom_range(0, PIN_W - 1));
				end
				pins = held_pins;
				if (pick >= 16 && pick < 22) begin
					pins = PIN_W'($urandom_range(0, 255));
				end
				send_sample(stamp, pins);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("button_debounce_report_scheduler_unit verification clean");
		end else begin
			$display("button_debounce_report_scheduler_unit verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/dbr_pkg.sv
rtl/dbr_channel.sv
rtl/dbr_sched.sv
rtl/button_debounce_report_scheduler_unit.sv
tb/debounce_report_checker.sv
tb/testbench.sv
